// ===== rtl/hefc_pkg.sv =====
// Shared types, codes and a helper function of the HID event flow control block.
package hefc_pkg;

  // Input item kinds.
  localparam logic [2:0] KIND_SUBMIT_ACTION = 3'd0;
  localparam logic [2:0] KIND_SUBMIT_DELTA  = 3'd1;
  localparam logic [2:0] KIND_SUBMIT_REPORT = 3'd2;
  localparam logic [2:0] KIND_KBD_SERVICE   = 3'd3;
  localparam logic [2:0] KIND_CONSUMER_RND  = 3'd4;

  // Result kinds.
  localparam logic [1:0] RES_STATUS   = 2'd0;
  localparam logic [1:0] RES_REPORT   = 2'd1;
  localparam logic [1:0] RES_DISPATCH = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // Configuration port.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_CONSUMER_MASK = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CW_ACTION     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CCW_ACTION    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROUND_BUDGET  = 2'd3;
  localparam logic [4:0] BUDGET_RESET = 5'd4;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         action_code;
    logic signed [15:0] encoder_delta;
    logic [63:0]        report_word;
    logic               consumer_link_ready;
    logic               keyboard_link_ready;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  out_action;
    logic [63:0] out_report;
    logic [1:0]  status;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [15:0] consumer_mask;
    logic [7:0]  cw_action;
    logic [7:0]  ccw_action;
    logic [4:0]  round_budget;
  } cfg_t;

  typedef enum logic [2:0] {
    OP_ACTION,
    OP_DELTA,
    OP_REPORT,
    OP_SERVICE,
    OP_ROUND,
    OP_NOP
  } cmd_op_e;

  // Classified request handed from the front end to the execution side.
  typedef struct packed {
    cmd_op_e            op;
    logic [7:0]         action;
    logic               act_link;
    logic signed [15:0] delta;
    logic [63:0]        report;
    logic               cready;
    logic               kready;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FIFO,
    BK_ROT,
    BK_REPORT,
    BK_STATUS
  } back_state_e;

  // Only codes below 16 can be of consumer class.
  function automatic logic needs_link(input logic [15:0] mask, input logic [7:0] act);
    return (act[7:4] == 4'd0) && mask[act[3:0]];
  endfunction

endpackage

// ===== rtl/hefc_front.sv =====
// Front end: accepts requests, classifies them and buffers them in a two-entry queue.
module hefc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  hefc_pkg::in_item_t in_data_i,
  input  logic [15:0]       mask_i,
  output logic              cmd_valid_o,
  output hefc_pkg::cmd_t    cmd_o,
  input  logic              cmd_pop_i
);

  hefc_pkg::cmd_t slot_q [2];
  hefc_pkg::cmd_t cmd_new;
  logic           head_q, head_d;
  logic           tail_q, tail_d;
  logic [1:0]     count_q, count_d;
  logic           push, pop;

  always_comb begin
    cmd_new.action   = in_data_i.action_code;
    cmd_new.act_link = hefc_pkg::needs_link(mask_i, in_data_i.action_code);
    cmd_new.delta    = in_data_i.encoder_delta;
    cmd_new.report   = in_data_i.report_word;
    cmd_new.cready   = in_data_i.consumer_link_ready;
    cmd_new.kready   = in_data_i.keyboard_link_ready;
    unique case (in_data_i.kind)
      hefc_pkg::KIND_SUBMIT_ACTION: cmd_new.op = hefc_pkg::OP_ACTION;
      hefc_pkg::KIND_SUBMIT_DELTA:  cmd_new.op = hefc_pkg::OP_DELTA;
      hefc_pkg::KIND_SUBMIT_REPORT: cmd_new.op = hefc_pkg::OP_REPORT;
      hefc_pkg::KIND_KBD_SERVICE:   cmd_new.op = hefc_pkg::OP_SERVICE;
      hefc_pkg::KIND_CONSUMER_RND:  cmd_new.op = hefc_pkg::OP_ROUND;
      default:                      cmd_new.op = hefc_pkg::OP_NOP;
    endcase
  end

  assign in_stall_o  = (count_q == 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = slot_q[head_q];
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    head_d  = pop ? ~head_q : head_q;
    tail_d  = push ? ~tail_q : tail_q;
    count_d = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= 1'b0;
      tail_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[tail_q] <= cmd_new;
    end
  end

endmodule

// ===== rtl/hefc_back.sv =====
// Execution side: action FIFO, rotation total, report mailbox and result register.
module hefc_back #(
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned MAX_ROUND   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hefc_pkg::cfg_t     cfg_i,
  input  logic               cmd_valid_i,
  input  hefc_pkg::cmd_t     cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output hefc_pkg::out_item_t out_data_o
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned RW = $clog2(MAX_ROUND + 1);
  localparam int unsigned CW = (RW > 5) ? RW : 5;

  hefc_pkg::back_state_e state_q, state_d;

  logic [7:0]         mem [QUEUE_DEPTH];
  logic [7:0]         rd_data_q;
  logic               mem_we;
  logic [AW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [AW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [FW-1:0]      fill_q, fill_d;
  logic signed [31:0] pending_q, pending_d;
  logic [63:0]        held_q, held_d;
  logic               waiting_q, waiting_d;
  logic [RW-1:0]      rem_q, rem_d;
  logic [1:0]         st_q, st_d;
  logic               cready_q, cready_d;

  logic                out_valid_q, out_valid_d;
  hefc_pkg::out_item_t out_q, out_item;
  logic                emit, out_free;

  logic signed [32:0] sum;
  logic signed [31:0] sat;
  logic [CW-1:0]      budget_ext;
  logic [RW-1:0]      budget_eff;
  logic [7:0]         rot_act;
  logic               drop;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    sum = 33'(pending_q) + 33'(cmd_i.delta);
    // Clamp at the signed 32-bit bounds when the sum leaves that range.
    if (sum[32] != sum[31]) begin
      sat = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat = sum[31:0];
    end
    budget_ext = CW'(cfg_i.round_budget);
    budget_eff = (budget_ext > CW'(MAX_ROUND)) ? RW'(MAX_ROUND) : RW'(budget_ext);
    rot_act    = (pending_q > 32'sd0) ? cfg_i.cw_action : cfg_i.ccw_action;
  end

  always_comb begin
    state_d   = state_q;
    rd_ptr_d  = rd_ptr_q;
    wr_ptr_d  = wr_ptr_q;
    fill_d    = fill_q;
    pending_d = pending_q;
    held_d    = held_q;
    waiting_d = waiting_q;
    rem_d     = rem_q;
    st_d      = st_q;
    cready_d  = cready_q;
    mem_we    = 1'b0;
    cmd_pop_o = 1'b0;
    emit      = 1'b0;
    out_item  = '0;
    drop      = 1'b0;

    unique case (state_q)
      hefc_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          st_d      = hefc_pkg::ST_OK;
          state_d   = hefc_pkg::BK_STATUS;
          unique case (cmd_i.op)
            hefc_pkg::OP_ACTION: begin
              // The link check takes precedence over the full check.
              if (cmd_i.act_link && !cmd_i.cready) begin
                st_d = hefc_pkg::ST_DROPPED;
              end else if (fill_q == FW'(QUEUE_DEPTH)) begin
                st_d = hefc_pkg::ST_FULL;
              end else begin
                mem_we   = 1'b1;
                wr_ptr_d = (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
                fill_d   = fill_q + 1'b1;
              end
            end
            hefc_pkg::OP_DELTA: begin
              if (cmd_i.delta != 16'sd0) begin
                if (!cmd_i.cready) begin
                  st_d = hefc_pkg::ST_DROPPED;
                end else begin
                  pending_d = sat;
                end
              end
            end
            hefc_pkg::OP_REPORT: begin
              held_d    = cmd_i.report;
              waiting_d = 1'b1;
            end
            hefc_pkg::OP_SERVICE: begin
              if (waiting_q) begin
                waiting_d = 1'b0;
                if (!cmd_i.kready) begin
                  st_d = hefc_pkg::ST_DROPPED;
                end else begin
                  state_d = hefc_pkg::BK_REPORT;
                end
              end
            end
            hefc_pkg::OP_ROUND: begin
              rem_d    = budget_eff;
              cready_d = cmd_i.cready;
              state_d  = hefc_pkg::BK_FIFO;
            end
            default: begin
            end
          endcase
        end
      end

      hefc_pkg::BK_FIFO: begin
        if (rem_q == '0 || fill_q == '0) begin
          state_d = hefc_pkg::BK_ROT;
        end else if (out_free) begin
          drop                 = hefc_pkg::needs_link(cfg_i.consumer_mask, rd_data_q) && !cready_q;
          emit                 = 1'b1;
          out_item.result_kind = hefc_pkg::RES_DISPATCH;
          out_item.out_action  = rd_data_q;
          out_item.status      = drop ? hefc_pkg::ST_DROPPED : hefc_pkg::ST_OK;
          if (drop) begin
            st_d = hefc_pkg::ST_DROPPED;
          end
          rd_ptr_d = (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
          fill_d   = fill_q - 1'b1;
          rem_d    = rem_q - 1'b1;
        end
      end

      hefc_pkg::BK_ROT: begin
        if (rem_q == '0 || pending_q == 32'sd0) begin
          state_d = hefc_pkg::BK_STATUS;
        end else if (out_free) begin
          drop                 = hefc_pkg::needs_link(cfg_i.consumer_mask, rot_act) && !cready_q;
          emit                 = 1'b1;
          out_item.result_kind = hefc_pkg::RES_DISPATCH;
          out_item.out_action  = rot_act;
          out_item.status      = drop ? hefc_pkg::ST_DROPPED : hefc_pkg::ST_OK;
          if (drop) begin
            st_d = hefc_pkg::ST_DROPPED;
          end
          pending_d = (pending_q > 32'sd0) ? pending_q - 32'sd1 : pending_q + 32'sd1;
          rem_d     = rem_q - 1'b1;
        end
      end

      hefc_pkg::BK_REPORT: begin
        if (out_free) begin
          emit                 = 1'b1;
          out_item.result_kind = hefc_pkg::RES_REPORT;
          out_item.out_report  = held_q;
          out_item.status      = hefc_pkg::ST_OK;
          state_d              = hefc_pkg::BK_STATUS;
        end
      end

      hefc_pkg::BK_STATUS: begin
        if (out_free) begin
          emit                 = 1'b1;
          out_item.result_kind = hefc_pkg::RES_STATUS;
          out_item.status      = st_q;
          out_item.last_of_run = 1'b1;
          state_d              = hefc_pkg::BK_IDLE;
        end
      end

      default: begin
        state_d = hefc_pkg::BK_IDLE;
      end
    endcase

    out_valid_d = emit ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hefc_pkg::BK_IDLE;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      fill_q      <= '0;
      pending_q   <= '0;
      held_q      <= '0;
      waiting_q   <= 1'b0;
      rem_q       <= '0;
      st_q        <= hefc_pkg::ST_OK;
      cready_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      fill_q      <= fill_d;
      pending_q   <= pending_d;
      held_q      <= held_d;
      waiting_q   <= waiting_d;
      rem_q       <= rem_d;
      st_q        <= st_d;
      cready_q    <= cready_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The read port follows the next read pointer, so rd_data_q always shows the
  // FIFO head; a write to that same entry is forwarded.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_ptr_q] <= cmd_i.action;
    end
    if (mem_we && (wr_ptr_q == rd_ptr_d)) begin
      rd_data_q <= cmd_i.action;
    end else begin
      rd_data_q <= mem[rd_ptr_d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/hid_event_flow_control.sv =====
// Top level of the HID event flow control block: configuration registers and the two halves.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    hefc_pkg::in_item_t
//   out      output     out_valid_o / out_stall_i  hefc_pkg::out_item_t
//   cfg      input      cfg_we_i                   cfg_index_i, cfg_wdata_i
//
// A two-entry request queue sits between the front end and the execution side.
// Submits, unused kinds and a service with nothing waiting go from the idle state to the
// status state in the execution side; a service that sends a report passes through the
// report state first. A consumer round passes through the FIFO, rotation and status states;
// the single result register carries one result per cycle while the output is not stalled.
// Reset is asynchronous and clears all control state; no clearing pass is needed.
// A stall on the output holds the execution side; the input keeps filling the queue.
module hid_event_flow_control #(
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned MAX_ROUND   = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  hefc_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output hefc_pkg::out_item_t                out_data_o,
  input  logic                               cfg_we_i,
  input  logic [hefc_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [hefc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  hefc_pkg::cfg_t cfg_q, cfg_d;
  hefc_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        hefc_pkg::CFG_CONSUMER_MASK: cfg_d.consumer_mask = cfg_wdata_i;
        hefc_pkg::CFG_CW_ACTION:     cfg_d.cw_action     = cfg_wdata_i[7:0];
        hefc_pkg::CFG_CCW_ACTION:    cfg_d.ccw_action    = cfg_wdata_i[7:0];
        hefc_pkg::CFG_ROUND_BUDGET:  cfg_d.round_budget  = cfg_wdata_i[4:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.consumer_mask <= '0;
      cfg_q.cw_action     <= '0;
      cfg_q.ccw_action    <= '0;
      cfg_q.round_budget  <= hefc_pkg::BUDGET_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  hefc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .mask_i      (cfg_q.consumer_mask),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  hefc_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_ROUND   (MAX_ROUND)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/hefc_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
module hefc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_stall_i,
  input hefc_pkg::out_item_t out_data_i
);

  // A stalled result request holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed");

  // Only the final status result closes a run.
  a_last_is_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.last_of_run == (out_data_i.result_kind == hefc_pkg::RES_STATUS)))
    else $error("last_of_run does not match result kind");

  // A sent report carries no action and an ok status.
  a_report_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.result_kind == hefc_pkg::RES_REPORT
    |-> out_data_i.out_action == 8'd0 && out_data_i.status == hefc_pkg::ST_OK)
    else $error("report result carries stray fields");

  // A dispatch attempt never carries a report word or a queue-full status.
  a_dispatch_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.result_kind == hefc_pkg::RES_DISPATCH
    |-> out_data_i.out_report == 64'd0 && out_data_i.status != hefc_pkg::ST_FULL)
    else $error("dispatch result carries stray fields");

  // Result kind three is never produced.
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.result_kind != 2'd3)
    else $error("unknown result kind");

endmodule

bind hid_event_flow_control hefc_checker u_hefc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the HID event flow control block.
module tb;

  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned MAX_ROUND   = 16;
  localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
  localparam longint ROTATION_MAX = 64'sd2147483647;
  localparam longint ROTATION_MIN = -64'sd2147483648;

  logic                             clk_i       = 1'b0;
  logic                             rst_ni      = 1'b0;
  logic                             in_valid_i  = 1'b0;
  logic                             in_stall_o;
  hefc_pkg::in_item_t               in_data_i   = '0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  hefc_pkg::out_item_t              out_data_o;
  logic                             cfg_we_i    = 1'b0;
  logic [hefc_pkg::CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [hefc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i = '0;

  // Shadow of the block's config and state; the state follows each accepted request.
  logic [15:0] class_mask;
  logic [7:0]  cw_code;
  logic [7:0]  ccw_code;
  logic [4:0]  budget_reg;
  logic [7:0]  action_fifo [QUEUE_DEPTH];
  int unsigned fifo_head;
  int unsigned fifo_tail;
  int unsigned fifo_fill;
  int          pending_steps;
  logic [63:0] mailbox_report;
  bit          mailbox_full;

  hefc_pkg::out_item_t queued_hid_results[$];
  int                  mismatch_count = 0;
  bit                  idle_off = 1'b0;
  int                  hold_cycles = 0;

  hid_event_flow_control #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .MAX_ROUND  (MAX_ROUND)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic bit consumer_class(input logic [7:0] code);
    return (code < 8'd16) && class_mask[code[3:0]];
  endfunction

  function automatic hefc_pkg::out_item_t make_result(input logic [1:0] kind,
                                                      input logic [7:0] code,
                                                      input logic [63:0] report,
                                                      input logic [1:0] st,
                                                      input logic last);
    hefc_pkg::out_item_t res;
    res.result_kind = kind;
    res.out_action  = code;
    res.out_report  = report;
    res.status      = st;
    res.last_of_run = last;
    return res;
  endfunction

  function automatic hefc_pkg::in_item_t make_request(input logic [2:0] kind,
                                                      input logic [7:0] code,
                                                      input logic signed [15:0] delta,
                                                      input logic [63:0] report,
                                                      input logic cready,
                                                      input logic kready);
    hefc_pkg::in_item_t item;
    item.kind                = kind;
    item.action_code         = code;
    item.encoder_delta       = delta;
    item.report_word         = report;
    item.consumer_link_ready = cready;
    item.keyboard_link_ready = kready;
    return item;
  endfunction

  function automatic hefc_pkg::in_item_t random_request();
    hefc_pkg::in_item_t item;
    int                 pick;
    pick = $urandom_range(99);
    if (pick < 30) item.kind = hefc_pkg::KIND_SUBMIT_ACTION;
    else if (pick < 48) item.kind = hefc_pkg::KIND_SUBMIT_DELTA;
    else if (pick < 60) item.kind = hefc_pkg::KIND_SUBMIT_REPORT;
    else if (pick < 72) item.kind = hefc_pkg::KIND_KBD_SERVICE;
    else if (pick < 94) item.kind = hefc_pkg::KIND_CONSUMER_RND;
    else item.kind = 3'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
    item.action_code = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(15));
    item.encoder_delta = ($urandom_range(9) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(10)) - 16'd5;
    item.report_word = {$urandom, $urandom};
    item.consumer_link_ready = ($urandom_range(9) != 0);
    item.keyboard_link_ready = ($urandom_range(9) != 0);
    return item;
  endfunction

  task automatic dispatch_action(input logic [7:0] code, input logic cready,
                                 inout logic [1:0] final_status);
    logic [1:0] st;
    st = (consumer_class(code) && !cready) ? hefc_pkg::ST_DROPPED : hefc_pkg::ST_OK;
    if (st != hefc_pkg::ST_OK) final_status = st;
    queued_hid_results.push_back(make_result(hefc_pkg::RES_DISPATCH, code, 64'd0, st, 1'b0));
  endtask

  // Works out every result that one accepted request causes.
  task automatic step_hid_flow(input hefc_pkg::in_item_t item);
    logic [1:0]  final_status;
    int unsigned budget;
    int unsigned tries;
    longint      sum;
    logic [7:0]  code;
    final_status = hefc_pkg::ST_OK;
    tries = 0;
    case (item.kind)
      hefc_pkg::KIND_SUBMIT_ACTION: begin
        if (consumer_class(item.action_code) && !item.consumer_link_ready) begin
          final_status = hefc_pkg::ST_DROPPED;
        end else if (fifo_fill >= QUEUE_DEPTH) begin
          final_status = hefc_pkg::ST_FULL;
        end else begin
          action_fifo[fifo_tail] = item.action_code;
          fifo_tail = (fifo_tail + 1) % QUEUE_DEPTH;
          fifo_fill++;
        end
      end
      hefc_pkg::KIND_SUBMIT_DELTA: begin
        if (item.encoder_delta != 16'sd0) begin
          if (!item.consumer_link_ready) begin
            final_status = hefc_pkg::ST_DROPPED;
          end else begin
            sum = longint'(pending_steps) + longint'(item.encoder_delta);
            if (sum > ROTATION_MAX) sum = ROTATION_MAX;
            if (sum < ROTATION_MIN) sum = ROTATION_MIN;
            pending_steps = int'(sum);
          end
        end
      end
      hefc_pkg::KIND_SUBMIT_REPORT: begin
        mailbox_report = item.report_word;
        mailbox_full = 1'b1;
      end
      hefc_pkg::KIND_KBD_SERVICE: begin
        if (mailbox_full) begin
          mailbox_full = 1'b0;
          if (!item.keyboard_link_ready) final_status = hefc_pkg::ST_DROPPED;
          else queued_hid_results.push_back(make_result(hefc_pkg::RES_REPORT, 8'd0,
                                                        mailbox_report, hefc_pkg::ST_OK,
                                                        1'b0));
        end
      end
      hefc_pkg::KIND_CONSUMER_RND: begin
        budget = (budget_reg > MAX_ROUND) ? MAX_ROUND : budget_reg;
        while (tries < budget && fifo_fill > 0) begin
          code = action_fifo[fifo_head];
          fifo_head = (fifo_head + 1) % QUEUE_DEPTH;
          fifo_fill--;
          tries++;
          dispatch_action(code, item.consumer_link_ready, final_status);
        end
        while (tries < budget && pending_steps != 0) begin
          if (pending_steps > 0) begin
            pending_steps--;
            code = cw_code;
          end else begin
            pending_steps++;
            code = ccw_code;
          end
          tries++;
          dispatch_action(code, item.consumer_link_ready, final_status);
        end
      end
      default: ;
    endcase
    queued_hid_results.push_back(make_result(hefc_pkg::RES_STATUS, 8'd0, 64'd0, final_status,
                                             1'b1));
  endtask

  // Offers one request, with a random gap first, and returns once it is accepted.
  // Valid stays high so that a following request can go out on the next edge.
  task automatic send_request(input hefc_pkg::in_item_t item);
    while (!idle_off && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    step_hid_flow(item);
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (queued_hid_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [15:0] mask, input logic [7:0] cw,
                              input logic [7:0] ccw, input logic [4:0] budget);
    wait_for_drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= hefc_pkg::CFG_CONSUMER_MASK;
    cfg_wdata_i <= mask;
    @(posedge clk_i);
    cfg_index_i <= hefc_pkg::CFG_CW_ACTION;
    cfg_wdata_i <= {8'd0, cw};
    @(posedge clk_i);
    cfg_index_i <= hefc_pkg::CFG_CCW_ACTION;
    cfg_wdata_i <= {8'd0, ccw};
    @(posedge clk_i);
    cfg_index_i <= hefc_pkg::CFG_ROUND_BUDGET;
    cfg_wdata_i <= {11'd0, budget};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    class_mask = mask;
    cw_code    = cw;
    ccw_code   = ccw;
    budget_reg = budget;
  endtask

  task automatic test_reset_defaults();
    send_request(make_request(hefc_pkg::KIND_SUBMIT_DELTA, 8'd0, 16'sd6, 64'd0, 1'b1, 1'b1));
    send_request(make_request(hefc_pkg::KIND_CONSUMER_RND, 8'd0, 16'sd0, 64'd0, 1'b1, 1'b1));
    send_request(make_request(hefc_pkg::KIND_CONSUMER_RND, 8'd0, 16'sd0, 64'd0, 1'b1, 1'b1));
    wait_for_drain();
  endtask

  task automatic test_directed_cases();
    apply_config(16'h00F0, 8'h05, 8'hFF, 5'd16);
    // Codes 4..7 are consumer class here; the link is checked before the fill level.
    send_request(make_request(hefc_pkg::KIND_SUBMIT_ACTION, 8'h00, 16'sd0, 64'd0, 1'b0, 1'b1));
    send_request(make_request(hefc_pkg::KIND_SUBMIT_ACTION, 8'h04, 16'sd0, 64'd0, 1'b0, 1'b1));
    send_request(make_request(hefc_pkg::KIND_SUBMIT_ACTION, 8'hFF, 16'sd0, 64'd0, 1'b0, 1'b1));
    repeat (6) begin
      send_request(make_request(hefc_pkg::KIND_SUBMIT_ACTION, 8'h05, 16'sd0, 64'd0,
                                1'b1, 1'b1));
    end
    send_request(make_request(hefc_pkg::KIND_SUBMIT_ACTION, 8'h04, 16'sd0, 64'd0, 1'b0, 1'b1));
    send_request(make_request(hefc_pkg::KIND_SUBMIT_ACTION, 8'h01, 16'sd0, 64'd0, 1'b1, 1'b1));
    send_request(make_request(hefc_pkg::KIND_SUBMIT_DELTA, 8'd0, 16'sd0, 64'd0, 1'b0, 1'b0));
    send_request(make_request(hefc_pkg::KIND_SUBMIT_DELTA, 8'd0, 16'sd32767, 64'd0,
                              1'b0, 1'b1));
    send_request(make_request(hefc_pkg::KIND_SUBMIT_DELTA, 8'd0, 16'sd32767, 64'd0,
                              1'b1, 1'b1));
    send_request(make_request(hefc_pkg::KIND_SUBMIT_DELTA, 8'd0, 16'sh8000, 64'd0,
                              1'b1, 1'b1));
    send_request(make_request(hefc_pkg::KIND_SUBMIT_DELTA, 8'd0, 16'sd3, 64'd0, 1'b1, 1'b1));
    send_request(make_request(hefc_pkg::KIND_CONSUMER_RND, 8'd0, 16'sd0, 64'd0, 1'b0, 1'b1));
    // The latest report wins the mailbox.
    send_request(make_request(hefc_pkg::KIND_SUBMIT_REPORT, 8'd0, 16'sd0, 64'd0, 1'b1, 1'b1));
    send_request(make_request(hefc_pkg::KIND_SUBMIT_REPORT, 8'd0, 16'sd0, '1, 1'b1, 1'b1));
    send_request(make_request(hefc_pkg::KIND_KBD_SERVICE, 8'd0, 16'sd0, 64'd0, 1'b1, 1'b1));
    send_request(make_request(hefc_pkg::KIND_KBD_SERVICE, 8'd0, 16'sd0, 64'd0, 1'b1, 1'b1));
    send_request(make_request(hefc_pkg::KIND_SUBMIT_REPORT, 8'd0, 16'sd0, 64'h0123456789ABCDEF,
                              1'b1, 1'b1));
    send_request(make_request(hefc_pkg::KIND_KBD_SERVICE, 8'd0, 16'sd0, 64'd0, 1'b1, 1'b0));
    send_request(make_request(KIND_UNUSED_HI, 8'hFF, 16'sd1, '1, 1'b0, 1'b0));
    send_request(make_request(hefc_pkg::KIND_CONSUMER_RND, 8'd0, 16'sd0, 64'd0, 1'b1, 1'b1));
    wait_for_drain();
  endtask

  task automatic test_round_budget();
    // A zero budget dispatches nothing; one above the maximum acts as the maximum.
    apply_config(16'h0000, 8'h00, 8'h80, 5'd0);
    send_request(make_request(hefc_pkg::KIND_SUBMIT_ACTION, 8'h09, 16'sd0, 64'd0, 1'b1, 1'b1));
    send_request(make_request(hefc_pkg::KIND_CONSUMER_RND, 8'd0, 16'sd0, 64'd0, 1'b1, 1'b1));
    apply_config(16'h0000, 8'h00, 8'h80, 5'd31);
    send_request(make_request(hefc_pkg::KIND_SUBMIT_DELTA, 8'd0, -16'sd20, 64'd0, 1'b1, 1'b1));
    send_request(make_request(hefc_pkg::KIND_CONSUMER_RND, 8'd0, 16'sd0, 64'd0, 1'b1, 1'b1));
    send_request(make_request(hefc_pkg::KIND_CONSUMER_RND, 8'd0, 16'sd0, 64'd0, 1'b1, 1'b1));
    wait_for_drain();
  endtask

  task automatic test_random_traffic();
    hefc_pkg::in_item_t item;
    int                 sent;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: apply_config(16'h0000, 8'h00, 8'hFF, 5'd1);
        1: apply_config(16'hFFFF, 8'hFF, 8'h00, 5'd16);
        default: apply_config(16'($urandom), 8'($urandom_range(15)), 8'($urandom_range(15)),
                              5'($urandom_range(16, 1)));
      endcase
      idle_off = (phase == 2);
      sent = 0;
      while (sent < 14) begin
        item = random_request();
        send_request(item);
        sent++;
        // A large rotation is taken back at once so that rounds still reach the queue.
        if (item.kind == hefc_pkg::KIND_SUBMIT_DELTA && item.consumer_link_ready &&
            (item.encoder_delta > 16'sd64 || item.encoder_delta < -16'sd64)) begin
          item.encoder_delta = -item.encoder_delta;
          send_request(item);
          sent++;
        end
      end
      idle_off = 1'b0;
    end
    wait_for_drain();
  endtask

  task automatic test_backpressure();
    apply_config(16'h0F0F, 8'h03, 8'h0C, 5'd8);
    hold_cycles = 150;
    repeat (14) send_request(random_request());
    wait_for_drain();
  endtask

  task automatic test_large_rotation();
    // Totals beyond the range of one delta, then back across zero.
    apply_config(16'h0000, 8'hA5, 8'h5A, 5'd16);
    repeat (2) begin
      send_request(make_request(hefc_pkg::KIND_SUBMIT_DELTA, 8'd0, 16'sd32767, 64'd0,
                                1'b1, 1'b1));
    end
    send_request(make_request(hefc_pkg::KIND_CONSUMER_RND, 8'd0, 16'sd0, 64'd0, 1'b1, 1'b1));
    repeat (2) begin
      send_request(make_request(hefc_pkg::KIND_SUBMIT_DELTA, 8'd0, 16'sh8000, 64'd0,
                                1'b1, 1'b1));
    end
    send_request(make_request(hefc_pkg::KIND_CONSUMER_RND, 8'd0, 16'sd0, 64'd0, 1'b1, 1'b1));
    send_request(make_request(hefc_pkg::KIND_CONSUMER_RND, 8'd0, 16'sd0, 64'd0, 1'b1, 1'b1));
    wait_for_drain();
  endtask

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall_i <= !idle_off && ($urandom_range(99) < 7);
    end
  end

  task automatic compare_field(input string field_name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s expected %0h actual %0h", $time, field_name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    hefc_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (queued_hid_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result expected none actual %0h", $time, out_data_o);
      end else begin
        want = queued_hid_results.pop_front();
        compare_field("result_kind", want.result_kind, out_data_o.result_kind);
        compare_field("out_action", want.out_action, out_data_o.out_action);
        compare_field("out_report", want.out_report, out_data_o.out_report);
        compare_field("status", want.status, out_data_o.status);
        compare_field("last_of_run", want.last_of_run, out_data_o.last_of_run);
      end
    end
  end

  initial begin
    #8000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    class_mask     = 16'd0;
    cw_code        = 8'd0;
    ccw_code       = 8'd0;
    budget_reg     = hefc_pkg::BUDGET_RESET;
    fifo_head      = 0;
    fifo_tail      = 0;
    fifo_fill      = 0;
    pending_steps  = 0;
    mailbox_report = 64'd0;
    mailbox_full   = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed_cases();
    test_round_budget();
    test_random_traffic();
    test_backpressure();
    test_large_rotation();
    wait_for_drain();
    repeat (32) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== hid_event_flow_control.f =====
rtl/hefc_pkg.sv
rtl/hefc_front.sv
rtl/hefc_back.sv
rtl/hid_event_flow_control.sv
rtl/hefc_checker.sv
tb/tb.sv
